>>> rtl/dft_pkg.sv
// ----------------------------------------------------------------------------
// dft_pkg: shared definitions for the dual fan tachometer
// Widths, function codes, state encoding and the controller/datapath links.
// ----------------------------------------------------------------------------
package dft_pkg;

  localparam int CHANNELS     = 2;
  localparam int CH_IDX_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int STAMP_W      = 16;
  localparam int RPM_W        = 16;
  localparam int DIV_STEPS    = RPM_W;
  localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
  localparam logic [15:0] RPM_NUMERATOR_RESET = 16'd30000;

  typedef enum logic [1:0] {
    FN_TICK    = 2'd0,
    FN_STAMP   = 2'd1,
    FN_MEASURE = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic tick;
    logic stamp;
    logic measure;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_free;
  } status_t;

endpackage

>>> rtl/dft_ctrl.sv
// ----------------------------------------------------------------------------
// dft_ctrl: sequencing state machine of the fan tachometer
// Decodes accepted items and steps the serial divider through a measure.
// ----------------------------------------------------------------------------
module dft_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  logic [1:0]       func,
  input  logic             ch_ok,
  input  dft_pkg::status_t status,
  output logic             in_ready,
  output dft_pkg::cmd_t    cmd
);

  dft_pkg::state_t state;
  dft_pkg::state_t state_next;
  logic            accept;

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dft_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dft_pkg::ST_IDLE: begin
        if (accept && ch_ok && (func == dft_pkg::FN_MEASURE)) begin
          state_next = dft_pkg::ST_DIV;
        end
      end
      dft_pkg::ST_DIV: begin
        if (status.div_last) begin
          state_next = dft_pkg::ST_DONE;
        end
      end
      dft_pkg::ST_DONE: begin
        if (status.out_free) begin
          state_next = dft_pkg::ST_IDLE;
        end
      end
      default: state_next = dft_pkg::ST_IDLE;
    endcase
  end

  // In the idle state the input is always ready, so a valid item is accepted.
  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    unique case (state)
      dft_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (func)
            dft_pkg::FN_TICK:    cmd.tick    = 1'b1;
            dft_pkg::FN_STAMP:   cmd.stamp   = ch_ok;
            dft_pkg::FN_MEASURE: cmd.measure = ch_ok;
            default: ;
          endcase
        end
      end
      dft_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      dft_pkg::ST_DONE: begin
        cmd.out_load = status.out_free;
      end
      default: ;
    endcase
  end

endmodule

>>> rtl/dft_datapath.sv
// ----------------------------------------------------------------------------
// dft_datapath: counter, timestamps, serial divider and result register
// Executes the controller's commands; reports divider and output status.
// ----------------------------------------------------------------------------
module dft_datapath (
  input  logic                         clk,
  input  logic                         rst,
  input  dft_pkg::cmd_t                cmd,
  input  logic [dft_pkg::CH_IDX_W-1:0] ch_idx,
  input  logic                         cfg_wr_en,
  input  logic [15:0]                  cfg_wr_data,
  input  logic                         out_ready,
  output dft_pkg::status_t             status,
  output logic                         out_valid,
  output logic [dft_pkg::RPM_W-1:0]    out_rpm,
  output logic                         out_no_signal
);

  logic [15:0]                  rpm_numerator;
  logic [dft_pkg::STAMP_W-1:0]  tick_count;
  logic [dft_pkg::STAMP_W-1:0]  previous_stamp [dft_pkg::CHANNELS];
  logic [dft_pkg::STAMP_W-1:0]  latest_stamp   [dft_pkg::CHANNELS];
  logic [dft_pkg::STAMP_W-1:0]  interval;

  logic [dft_pkg::RPM_W:0]      div_rem;
  logic [dft_pkg::RPM_W-1:0]    div_quot;
  logic [dft_pkg::STAMP_W-1:0]  div_den;
  logic [dft_pkg::DIV_CNT_W-1:0] div_cnt;
  logic                         zero_flag;
  logic [dft_pkg::RPM_W:0]      rem_shift;
  logic [dft_pkg::RPM_W:0]      rem_diff;
  logic                         rem_ge;

  assign interval = latest_stamp[ch_idx] - previous_stamp[ch_idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      rpm_numerator <= dft_pkg::RPM_NUMERATOR_RESET;
    end else if (cfg_wr_en) begin
      rpm_numerator <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick_count <= '0;
    end else if (cmd.tick) begin
      tick_count <= tick_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < dft_pkg::CHANNELS; i++) begin
        previous_stamp[i] <= '0;
        latest_stamp[i]   <= '0;
      end
    end else if (cmd.stamp) begin
      previous_stamp[ch_idx] <= latest_stamp[ch_idx];
      latest_stamp[ch_idx]   <= tick_count;
    end else if (cmd.measure) begin
      previous_stamp[ch_idx] <= '0;
      latest_stamp[ch_idx]   <= '0;
    end
  end

  // One restoring step per cycle: shift in the next dividend bit, subtract if it fits.
  assign rem_shift = {div_rem[dft_pkg::RPM_W-1:0], div_quot[dft_pkg::RPM_W-1]};
  assign rem_diff  = rem_shift - {1'b0, div_den};
  assign rem_ge    = (rem_shift >= {1'b0, div_den});

  always_ff @(posedge clk) begin
    if (cmd.measure) begin
      div_rem   <= '0;
      div_quot  <= rpm_numerator;
      div_den   <= interval;
      zero_flag <= (interval == '0);
    end else if (cmd.div_step) begin
      div_rem  <= rem_ge ? rem_diff : rem_shift;
      div_quot <= {div_quot[dft_pkg::RPM_W-2:0], rem_ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= '0;
    end else if (cmd.measure) begin
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + 1'b1;
    end
  end

  assign status.div_last = (div_cnt == dft_pkg::DIV_CNT_W'(dft_pkg::DIV_STEPS - 1));
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_rpm       <= zero_flag ? '0 : div_quot;
      out_no_signal <= zero_flag;
    end
  end

endmodule

>>> rtl/dual_fan_tachometer_core.sv
// ----------------------------------------------------------------------------
// dual_fan_tachometer_core: two-channel fan tachometer, period to rpm
// Counts millisecond ticks, stamps falling edges and divides to get rpm.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Contents
//  s_*       in         tdata[1:0] func, tuser[0] channel
//  m_*       out        tdata[15:0] rpm, tuser[0] no_signal
//  cfg_*     in         cfg_wr_data[15:0] rpm_numerator, written on cfg_wr_en
//
//  Tick, edge and ignored items are taken in the idle state and the input stays ready.
//  A measure latches the interval, runs sixteen iterations of the shared
//  restoring divider, and loads the result register once that is free.
//  The result register parts the sides, so later ticks and edges are taken
//  while a result waits; a new measure waits only for a free result register.
//  Reset (rst, synchronous) zeroes the counter and all stamps and loads the
//  numerator with 30000.
//
module dual_fan_tachometer_core (
  input  logic        clk,
  input  logic        rst,
  // Input transactions.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,      // [1:0] func, [7:2] zero
  input  logic [0:0]  s_tuser,      // [0] channel
  // Result transactions.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,      // [15:0] rpm
  output logic [0:0]  m_tuser,      // [0] no_signal
  // Configuration write of rpm_numerator.
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  dft_pkg::cmd_t                cmd;
  dft_pkg::status_t             status;
  logic [dft_pkg::CH_IDX_W-1:0] ch_idx;
  logic                         ch_ok;
  logic                         no_signal;

  // Edge and measure items for channels that are not built are dropped.
  assign ch_idx = dft_pkg::CH_IDX_W'(s_tuser[0]);
  assign ch_ok  = ({3'b000, s_tuser[0]} < 4'(dft_pkg::CHANNELS));

  dft_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (s_tdata[1:0]),
    .ch_ok    (ch_ok),
    .status   (status),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  dft_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .ch_idx        (ch_idx),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .out_ready     (m_tready),
    .status        (status),
    .out_valid     (m_tvalid),
    .out_rpm       (m_tdata),
    .out_no_signal (no_signal)
  );

  assign m_tuser[0] = no_signal;

  // The divider never runs while the input is open.
  a_div_blocks_input : assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> !s_tready)
    else $error("divider step while input ready");

  // A result is only loaded into a free output register.
  a_load_when_free : assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("result loaded over a pending result");

  // A measure closes the input for the division.
  a_measure_closes : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && (s_tdata[1:0] == dft_pkg::FN_MEASURE) && ch_ok)
      |=> !s_tready)
    else $error("input still open after measure");

  // A no-signal result always carries rpm zero.
  a_no_signal_zero : assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser[0]) |-> (m_tdata == 16'd0))
    else $error("no-signal result with nonzero rpm");

endmodule
